[hdl/qfc_pkg.sv]
package qfc_pkg;

  // Field types of the input and result items.
  typedef logic signed [11:0] sample_t;
  typedef logic signed [23:0] bandpass_t;
  typedef logic        [31:0] integ_t;

  // Low-pass output, kept in 20-bit two's complement.
  typedef logic signed [19:0] lowpass_t;

  // Delay line lengths of the filters.
  localparam int LP_TAPS  = 12;
  localparam int HP_TAPS  = 32;
  localparam int DER_TAPS = 4;

  // Queue between the filter front and the integrator back.
  localparam int QDEPTH = 4;
  localparam int QIDX   = $clog2(QDEPTH);

  // Quotient bits resolved in each divider stage.
  localparam int DIV_BITS = 4;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/qfc_if.sv]
// Channel carrying one ECG sample per item.
interface qfc_in_if;
  logic             valid;
  logic             ready;
  qfc_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Channel carrying one filtered result per item.
interface qfc_out_if;
  logic               valid;
  logic               ready;
  qfc_pkg::bandpass_t bandpassed;
  qfc_pkg::integ_t    integrated;

  modport source (output valid, output bandpassed, output integrated, input ready);
  modport sink   (input valid, input bandpassed, input integrated, output ready);
endinterface

[hdl/qfc_front.sv]
module qfc_front (
  input  logic               clk,
  input  logic               rst_n,
  qfc_in_if.sink             in_ch,
  input  qfc_pkg::q_stat_t   q_stat,
  output logic               push,
  output qfc_pkg::bandpass_t push_hp
);
  import qfc_pkg::*;

  // Low-pass state.
  sample_t   lpx_r [LP_TAPS];
  lowpass_t  y1_r;
  lowpass_t  y2_r;
  lowpass_t  lp_r;
  logic      lpv_r;

  // High-pass state.
  lowpass_t  hpx_r [HP_TAPS];
  bandpass_t hp_prev_r;

  logic                a_fire;
  logic                b_fire;
  logic signed [14:0]  lp_num;
  logic signed [14:0]  lp_adj;
  logic signed [9:0]   lp_q;
  logic signed [22:0]  lp_sum;
  lowpass_t            lp_nxt;
  logic signed [19:0]  cur_adj;
  logic signed [19:0]  old_adj;
  logic signed [25:0]  hp_sum;
  bandpass_t           hp_nxt;

  // Stage A takes a sample whenever stage B is empty or moving on.
  assign b_fire      = lpv_r && !q_stat.full;
  assign in_ch.ready = !lpv_r || b_fire;
  assign a_fire      = in_ch.valid && in_ch.ready;

  // Low-pass: y = 2*y1 - y2 + (x - 2*x6 + x12)/32, division truncating toward zero.
  always_comb begin
    lp_num = 15'(in_ch.sample) - (15'(lpx_r[5]) <<< 1) + 15'(lpx_r[11]);
    lp_adj = lp_num + {10'd0, {5{lp_num[14]}}};
    lp_q   = lp_adj[14:5];
    lp_sum = (23'(y1_r) <<< 1) - 23'(y2_r) + 23'(lp_q);
    lp_nxt = lp_sum[19:0];
  end

  // High-pass: y = y1 - x/32 + x16 - x17 + x32/32, wrapped to 24 bits.
  always_comb begin
    cur_adj = lp_r + {15'd0, {5{lp_r[19]}}};
    old_adj = hpx_r[HP_TAPS-1] + {15'd0, {5{hpx_r[HP_TAPS-1][19]}}};
    hp_sum  = 26'(hp_prev_r) - 26'($signed(cur_adj[19:5]))
            + 26'(hpx_r[15]) - 26'(hpx_r[16])
            + 26'($signed(old_adj[19:5]));
    hp_nxt  = hp_sum[23:0];
  end

  assign push    = b_fire;
  assign push_hp = hp_nxt;

  // Stage A registers and low-pass history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpv_r <= 1'b0;
      y1_r  <= '0;
      y2_r  <= '0;
      for (int i = 0; i < LP_TAPS; i++) lpx_r[i] <= '0;
    end else begin
      lpv_r <= a_fire || (lpv_r && !b_fire);
      if (a_fire) begin
        y1_r     <= lp_nxt;
        y2_r     <= y1_r;
        lpx_r[0] <= in_ch.sample;
        for (int i = 1; i < LP_TAPS; i++) lpx_r[i] <= lpx_r[i-1];
      end
    end
  end

  // Low-pass value waiting for stage B.
  always_ff @(posedge clk) begin
    if (a_fire) begin
      lp_r <= lp_nxt;
    end
  end

  // Stage B history, advanced when the item enters the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_prev_r <= '0;
      for (int i = 0; i < HP_TAPS; i++) hpx_r[i] <= '0;
    end else if (b_fire) begin
      hp_prev_r <= hp_nxt;
      hpx_r[0]  <= lp_r;
      for (int i = 1; i < HP_TAPS; i++) hpx_r[i] <= hpx_r[i-1];
    end
  end

endmodule

[hdl/qfc_queue.sv]
module qfc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  qfc_pkg::bandpass_t push_data,
  input  logic               pop,
  output qfc_pkg::bandpass_t head,
  output qfc_pkg::q_stat_t   stat
);
  import qfc_pkg::*;

  bandpass_t       mem_r [QDEPTH];
  logic [QIDX-1:0] wr_ptr_r;
  logic [QIDX-1:0] rd_ptr_r;
  logic [QIDX:0]   cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (QIDX+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  // Pointers and fill count; the sides only push when not full and pop when not empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/qfc_div.sv]
module qfc_div #(
  parameter int WINDOW_LEN = 30
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_v,
  input  logic [32+$clog2(WINDOW_LEN)-1:0]      in_sum,
  input  qfc_pkg::bandpass_t                    in_hp,
  output logic                                  out_v,
  output qfc_pkg::bandpass_t                    out_hp,
  output qfc_pkg::integ_t                       out_quo
);
  import qfc_pkg::*;

  localparam int CW  = $clog2(WINDOW_LEN);
  localparam int SW  = 32 + CW;
  localparam int NST = (SW + DIV_BITS - 1) / DIV_BITS;
  localparam int PW  = NST * DIV_BITS;
  localparam logic [CW:0] DIVISOR = (CW+1)'(WINDOW_LEN);

  logic [NST-1:0] v_r;
  logic [PW-1:0]  num_r [NST];
  logic [PW-1:0]  quo_r [NST];
  logic [CW-1:0]  rem_r [NST];
  bandpass_t      hp_r  [NST];

  logic [NST-1:0] src_v;
  logic [PW-1:0]  src_num [NST];
  logic [PW-1:0]  src_quo [NST];
  logic [CW-1:0]  src_rem [NST];
  bandpass_t      src_hp  [NST];

  logic [PW-1:0]  nxt_num [NST];
  logic [PW-1:0]  nxt_quo [NST];
  logic [CW-1:0]  nxt_rem [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    // Stage inputs: the window sum for the first stage, the previous stage otherwise.
    if (k == 0) begin : g_first
      assign src_v[k]   = in_v;
      assign src_num[k] = PW'(in_sum);
      assign src_quo[k] = '0;
      assign src_rem[k] = '0;
      assign src_hp[k]  = in_hp;
    end else begin : g_next
      assign src_v[k]   = v_r[k-1];
      assign src_num[k] = num_r[k-1];
      assign src_quo[k] = quo_r[k-1];
      assign src_rem[k] = rem_r[k-1];
      assign src_hp[k]  = hp_r[k-1];
    end

    // Restoring division, a few quotient bits per stage.
    always_comb begin
      logic [PW-1:0] num;
      logic [PW-1:0] quo;
      logic [CW:0]   t;
      num = src_num[k];
      quo = src_quo[k];
      t   = {1'b0, src_rem[k]};
      for (int b = 0; b < DIV_BITS; b++) begin
        t   = {t[CW-1:0], num[PW-1]};
        num = num << 1;
        if (t >= DIVISOR) begin
          t   = t - DIVISOR;
          quo = {quo[PW-2:0], 1'b1};
        end else begin
          quo = {quo[PW-2:0], 1'b0};
        end
      end
      nxt_num[k] = num;
      nxt_quo[k] = quo;
      nxt_rem[k] = t[CW-1:0];
    end

    // Stage valid bit.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= src_v[k];
      end
    end

    // Stage payload.
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= nxt_num[k];
        quo_r[k] <= nxt_quo[k];
        rem_r[k] <= nxt_rem[k];
        hp_r[k]  <= src_hp[k];
      end
    end
  end

  // The quotient never exceeds 32 bits since each window entry is at most 2^32-1.
  assign out_v   = v_r[NST-1];
  assign out_hp  = hp_r[NST-1];
  assign out_quo = quo_r[NST-1][31:0];

endmodule

[hdl/qfc_back.sv]
module qfc_back #(
  parameter int WINDOW_LEN = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  qfc_pkg::q_stat_t   q_stat,
  input  qfc_pkg::bandpass_t q_head,
  output logic               pop,
  qfc_out_if.source          out_ch
);
  import qfc_pkg::*;

  localparam int CW = $clog2(WINDOW_LEN);
  localparam int SW = 32 + CW;

  logic               en;
  logic               div_v;

  // Derivative stage.
  bandpass_t          der_r [DER_TAPS];
  logic               s1_v_r;
  bandpass_t          s1_hp_r;
  logic [23:0]        s1_mag_r;

  // Squaring stage.
  logic               s2_v_r;
  bandpass_t          s2_hp_r;
  logic [47:0]        s2_prod_r;

  // Window stage.
  integ_t             win_r [WINDOW_LEN];
  logic [SW-1:0]      sum_r;
  logic               s3_v_r;
  bandpass_t          s3_hp_r;

  logic signed [26:0] dsum;
  logic signed [26:0] dadj;
  bandpass_t          dv;
  logic [23:0]        mag;
  integ_t             sat;

  // The whole back pipeline moves together unless the result is held.
  assign en  = !div_v || out_ch.ready;
  assign pop = en && !q_stat.empty;

  // Five-point derivative (2x + x1 - x3 - 2x4)/8, truncating toward zero.
  always_comb begin
    dsum = (27'(q_head) <<< 1) + 27'(der_r[0]) - 27'(der_r[2]) - (27'(der_r[3]) <<< 1);
    dadj = dsum + {24'd0, {3{dsum[26]}}};
    dv   = dadj[26:3];
    mag  = dv[23] ? 24'(-dv) : 24'(dv);
  end

  // Squares above 32 bits clamp to all ones.
  assign sat = (|s2_prod_r[47:32]) ? '1 : s2_prod_r[31:0];

  // Valid bits and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sum_r  <= '0;
      for (int i = 0; i < DER_TAPS; i++) der_r[i] <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) win_r[i] <= '0;
    end else if (en) begin
      s1_v_r <= !q_stat.empty;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (!q_stat.empty) begin
        der_r[0] <= q_head;
        for (int i = 1; i < DER_TAPS; i++) der_r[i] <= der_r[i-1];
      end
      if (s2_v_r) begin
        sum_r    <= sum_r - SW'(win_r[WINDOW_LEN-1]) + SW'(sat);
        win_r[0] <= sat;
        for (int i = 1; i < WINDOW_LEN; i++) win_r[i] <= win_r[i-1];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_hp_r   <= q_head;
      s1_mag_r  <= mag;
      s2_hp_r   <= s1_hp_r;
      s2_prod_r <= 48'(s1_mag_r) * 48'(s1_mag_r);
      s3_hp_r   <= s2_hp_r;
    end
  end

  // Window average and the output register at its last stage.
  qfc_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (s3_v_r),
    .in_sum  (sum_r),
    .in_hp   (s3_hp_r),
    .out_v   (div_v),
    .out_hp  (out_ch.bandpassed),
    .out_quo (out_ch.integrated)
  );

  assign out_ch.valid = div_v;

endmodule

[hdl/qrs_filter_chain_unit.sv]
// Throughput: one item per cycle as long as the result side does not stall; the
// window-average divider is pipelined at four bits a stage.
// A four-item queue between the filters and the integrator absorbs output stalls.
// Reset (rst_n low, synchronous) clears all delay lines, the window sum and all valid bits.
module qrs_filter_chain_unit #(
  parameter int WINDOW_LEN = 30
) (
  input  logic      clk,
  input  logic      rst_n,
  qfc_in_if.sink    in_ch,
  qfc_out_if.source out_ch
);
  import qfc_pkg::*;

  logic      push;
  bandpass_t push_hp;
  logic      pop;
  bandpass_t q_head;
  q_stat_t   q_stat;

  // Low-pass and high-pass filters.
  qfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .push    (push),
    .push_hp (push_hp)
  );

  // Queue of band-passed values.
  qfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_hp),
    .pop       (pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // Derivative, squaring and moving-window integration.
  qfc_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_head (q_head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

[hdl/qfc_check.sv]
module qfc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input qfc_pkg::bandpass_t out_bandpassed,
  input qfc_pkg::integ_t    out_integrated
);
  import qfc_pkg::*;

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn while stalled");

  // A held result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bandpassed) && $stable(out_integrated))
    else $error("result item changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present right after reset");

  // The filter front is free right after reset.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind qrs_filter_chain_unit qfc_check u_qfc_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_bandpassed (out_ch.bandpassed),
  .out_integrated (out_ch.integrated)
);

[tb/sv/qfc_tb_pkg.sv]
package qfc_tb_pkg;
  import qfc_pkg::*;

  // One result item as the block should present it.
  typedef struct packed {
    bandpass_t bandpassed;
    integ_t    integrated;
  } chain_result_t;

  // Tracks the filter chain in software and checks each result item in order.
  class chain_tracker #(int WLEN = 30);
    longint          lp_in[LP_TAPS];
    longint          lp_out[2];
    longint          hp_in[HP_TAPS];
    longint          hp_last;
    longint          der_in[DER_TAPS];
    longint unsigned win_sq[WLEN];
    longint unsigned win_total;
    int              win_slot;
    chain_result_t   pending[$];
    int              failures;

    // Keep the low w bits of v as a two's complement value.
    static function longint wrap_to(longint v, int w);
      return (v <<< (64 - w)) >>> (64 - w);
    endfunction

    // Run one accepted sample through the chain and queue the result it yields.
    function void note_sample(sample_t s);
      longint          x;
      longint          num;
      longint          lp;
      longint          hp;
      longint          dv;
      longint          mag;
      longint unsigned sq;
      longint unsigned avg;
      chain_result_t   res;

      x = longint'(s);

      // Low-pass: double integrator over a truncated comb, wrapped to 20 bits.
      num = x - 2 * lp_in[5] + lp_in[11];
      lp  = wrap_to(2 * lp_out[0] - lp_out[1] + num / 32, 20);
      for (int i = LP_TAPS - 1; i > 0; i--) lp_in[i] = lp_in[i - 1];
      lp_in[0]  = x;
      lp_out[1] = lp_out[0];
      lp_out[0] = lp;

      // High-pass: delayed input minus a running 32-sample mean, 24 bits.
      hp = wrap_to(hp_last - lp / 32 + hp_in[15] - hp_in[16] + hp_in[31] / 32, 24);
      for (int i = HP_TAPS - 1; i > 0; i--) hp_in[i] = hp_in[i - 1];
      hp_in[0] = lp;
      hp_last  = hp;

      // Five-point derivative, truncated toward zero.
      dv = (2 * hp + der_in[0] - der_in[2] - 2 * der_in[3]) / 8;
      for (int i = DER_TAPS - 1; i > 0; i--) der_in[i] = der_in[i - 1];
      der_in[0] = hp;

      // Square, saturated at 32 bits.
      mag = (dv < 0) ? -dv : dv;
      sq  = mag * mag;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;

      // Moving-window sum over the last WLEN squares.
      win_total        = win_total - win_sq[win_slot] + sq;
      win_sq[win_slot] = sq;
      win_slot         = (win_slot == WLEN - 1) ? 0 : win_slot + 1;
      avg              = win_total / WLEN;
      if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;

      res.bandpassed = hp[23:0];
      res.integrated = avg[31:0];
      pending.push_back(res);
    endfunction

    // Count a failure; only the first few are printed.
    function void report(string what, longint want, longint got);
      failures++;
      if (failures <= 10)
        $display("%s mismatch: expected %0d, got %0d", what, want, got);
    endfunction

    // Compare one accepted result item with the oldest queued prediction.
    function void check_result(bandpass_t bp, integ_t ig);
      chain_result_t want;

      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result item with nothing pending: bandpassed %0d, integrated %0d",
                   bp, ig);
        return;
      end
      want = pending.pop_front();
      if (bp !== want.bandpassed) report("bandpassed", want.bandpassed, bp);
      if (ig !== want.integrated) report("integrated", want.integrated, ig);
    endfunction
  endclass

endpackage

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qfc_pkg::*;
  import qfc_tb_pkg::*;

  localparam int WIN_LEN     = 30;
  localparam int MIXED_ITEMS = 150;
  localparam int DRIFT_ITEMS = 280;
  localparam int CALM_ITEMS  = 60;
  localparam int SETTLE      = 40;
  localparam int CORNER_VALS [7] = '{0, 2047, -2048, -1, 1, 1365, -1366};

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    tx_valid  = 1'b0;
  sample_t tx_sample = '0;
  logic    rx_ready  = 1'b0;

  int tx_odds;
  int rx_odds;
  int rx_hold;
  bit calm;
  int recent[LP_TAPS];

  chain_tracker #(WIN_LEN) tracker;

  qfc_in_if  in_bus ();
  qfc_out_if out_bus ();

  assign in_bus.valid  = tx_valid;
  assign in_bus.sample = tx_sample;
  assign out_bus.ready = rx_ready;

  qrs_filter_chain_unit #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  // Clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side stalls in random bursts.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_ready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else if (!calm && rx_odds != 0 && $urandom_range(rx_odds) == 0) begin
      rx_ready <= 1'b0;
      rx_hold  <= $urandom_range(4);
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // Every accepted result item is checked against the prediction queue.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tracker.check_result(out_bus.bandpassed, out_bus.integrated);
  end

  // Offer one sample, possibly after an idle burst, and wait for its acceptance.
  task automatic send_sample(input int value);
    sample_t s;

    s = sample_t'(value);
    if (!calm && tx_odds != 0 && $urandom_range(tx_odds) == 0) begin
      tx_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    tx_valid  <= 1'b1;
    tx_sample <= s;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tracker.note_sample(s);
    for (int i = LP_TAPS - 1; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = int'(s);
  endtask

  initial begin
    int left;
    int seg_len;
    int kind;
    int amp;
    int step;
    int level;
    int gap;
    int v;
    int a;
    int b;
    int want;
    int need;
    int u;

    tracker = new();
    tx_odds = 3;
    rx_odds = 3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Corner values, then full-scale positive and negative steps.
    foreach (CORNER_VALS[i]) send_sample(CORNER_VALS[i]);
    repeat (8) send_sample(2047);
    repeat (8) send_sample(-2048);

    // Hold off until the pipeline has drained completely.
    tx_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);

    // Mixed segments: raw noise, extremes, triangle waves and beat-like spikes.
    left = MIXED_ITEMS;
    while (left > 0) begin
      seg_len = $urandom_range(60, 20);
      if (seg_len > left) seg_len = left;
      kind    = $urandom_range(3);
      tx_odds = $urandom_range(6);
      rx_odds <= $urandom_range(6);
      amp     = $urandom_range(2047, 64);
      step    = 1 + $urandom_range(amp / 4);
      level   = 0;
      gap     = 0;
      repeat (seg_len) begin
        case (kind)
          0: v = $urandom_range(4095);
          1: begin
            case ($urandom_range(3))
              0:       v = 2047;
              1:       v = -2048;
              2:       v = 0;
              default: v = -1;
            endcase
          end
          2: begin
            level += step;
            if (level > amp || level < -amp) begin
              step  = -step;
              level += 2 * step;
            end
            v = level;
          end
          default: begin
            if (gap == 0) gap = $urandom_range(40, 15);
            gap--;
            if (gap == 1) v = amp;
            else if (gap < 3) v = -amp / 3;
            else v = int'($urandom_range(40)) - 20;
          end
        endcase
        send_sample(v);
      end
      left -= seg_len;
    end

    // Drift run: each comb value is steered so that truncation always loses
    // in the same direction, which walks the low-pass output until it wraps
    // and the resulting jump saturates the square.
    tx_odds = 4;
    rx_odds <= 4;
    for (int n = 0; n < DRIFT_ITEMS; n++) begin
      if (n == DRIFT_ITEMS - CALM_ITEMS) calm <= 1'b1;
      a    = recent[5];
      b    = recent[11];
      want = a / 2 + int'($urandom_range(40)) - 20;
      need = want - 2 * a + b;
      if (need >= -31) u = 32 * ((need > 0 ? need : 0) / 32) + 31;
      else u = -32 * ((31 - need) / 32);
      v = u + 2 * a - b;
      if (v > 2047) v = 2047;
      else if (v < -2048) v = -2048;
      send_sample(v);
    end

    // Drain, then give any stray result items time to show up.
    tx_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/qfc_pkg.sv
hdl/qfc_if.sv
hdl/qfc_front.sv
hdl/qfc_queue.sv
hdl/qfc_div.sv
hdl/qfc_back.sv
hdl/qrs_filter_chain_unit.sv
hdl/qfc_check.sv
tb/sv/qfc_tb_pkg.sv
tb/sv/tb.sv
